FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Types and codes shared by the position item table.
// ----------------------------------------------------------------------------
package pit_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MARK_NONE  = 2'd0,
        MARK_SET   = 2'd1,
        MARK_CLEAR = 2'd2
    } t_mark;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_FILL = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    typedef struct packed {
        logic [7:0] kind_code;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] amount;
    } t_slot_rec;

    typedef struct packed {
        logic       success;
        logic [3:0] slot_out;
        t_mark      mark_action;
        logic [7:0] mark_x;
        logic [7:0] mark_y;
    } t_rsp;

    localparam t_rsp RSP_NONE = '{
        success:     1'b0,
        slot_out:    4'd0,
        mark_action: MARK_NONE,
        mark_x:      8'd0,
        mark_y:      8'd0
    };

endpackage

FILE: rtl/pit_ifs.sv
// ----------------------------------------------------------------------------
// pit_ifs
// Request and response channels of the position item table.
// ----------------------------------------------------------------------------
interface pit_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] kind_code;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] amount;
    logic [7:0] slot_in;

    modport source (
        output valid, operation, kind_code, pos_x, pos_y, amount, slot_in,
        input  ready
    );
    modport sink (
        input  valid, operation, kind_code, pos_x, pos_y, amount, slot_in,
        output ready
    );
endinterface

interface pit_rsp_if;
    logic       valid;
    logic       ready;
    logic       success;
    logic [3:0] slot_out;
    logic [1:0] mark_action;
    logic [7:0] mark_x;
    logic [7:0] mark_y;

    modport source (
        output valid, success, slot_out, mark_action, mark_x, mark_y,
        input  ready
    );
    modport sink (
        input  valid, success, slot_out, mark_action, mark_x, mark_y,
        output ready
    );
endinterface

FILE: rtl/pit_slot_store.sv
// ----------------------------------------------------------------------------
// pit_slot_store
// Slot record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pit_slot_store
    import pit_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot_rec     i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot_rec     o_rd_data
);

    t_slot_rec r_mem [DEPTH];
    t_slot_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/position_item_table_unit.sv
// ----------------------------------------------------------------------------
// position_item_table_unit
// Slot table with lookup, insert, remove and clear, scanned one slot a cycle.
// ----------------------------------------------------------------------------
// Channel   Port    Dir  Payload
// request   i_req   in   operation, kind_code, pos_x, pos_y, amount, slot_in
// response  o_rsp   out  success, slot_out, mark_action, mark_x, mark_y
//
// Lookup and remove walk the slot memory through the single compare unit, remove
// first reading the removed slot's position (ST_READ, ST_LOAD); insert walks the
// valid flags for a free slot; clear and rejects go straight to ST_DONE.
// One request in flight; a new one is taken while the last result waits.
// Reset empties the table at once through the per-slot valid flops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module position_item_table_unit
    import pit_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pit_req_if.sink   i_req,
    pit_rsp_if.source o_rsp
);

    localparam int             IW       = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0]  LP_LAST  = IW'(SLOT_COUNT - 1);
    localparam logic [7:0]     LP_LIMIT = 8'(SLOT_COUNT);

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [7:0]            r_tgt_x, n_tgt_x;
    logic [7:0]            r_tgt_y, n_tgt_y;
    logic [7:0]            r_kind, n_kind;
    logic [7:0]            r_amount, n_amount;
    logic [IW-1:0]         r_rm_idx, n_rm_idx;
    logic [IW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_rd_live, n_rd_live;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    t_rsp                  r_res, n_res;
    t_rsp                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    t_slot_rec     w_wr_data;
    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    t_slot_rec     w_rd_data;
    logic          w_accept;
    logic          w_in_range;
    logic          w_rm_live;
    logic          w_hit;

    function automatic logic [3:0] f_slot4(input logic [IW-1:0] idx);
        logic [7:0] wide;
        wide = 8'(idx);
        return wide[3:0];
    endfunction

    pit_slot_store #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_range  = (i_req.slot_in < LP_LIMIT);
    assign w_rm_live   = w_in_range ? r_valid[i_req.slot_in[IW-1:0]] : 1'b0;
    assign w_hit       = r_valid[r_rd_idx] && (w_rd_data.pos_x == r_tgt_x)
                         && (w_rd_data.pos_y == r_tgt_y);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_kind      = r_kind;
        n_amount    = r_amount;
        n_rm_idx    = r_rm_idx;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_rd_live   = r_rd_live;
        n_valid     = r_valid;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_data   = '{kind_code: r_kind, pos_x: r_tgt_x, pos_y: r_tgt_y,
                        amount: r_amount};
        w_rd_en     = 1'b0;
        w_rd_addr   = r_idx;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op      = t_op'(i_req.operation);
                    n_tgt_x   = i_req.pos_x;
                    n_tgt_y   = i_req.pos_y;
                    n_kind    = i_req.kind_code;
                    n_amount  = i_req.amount;
                    n_idx     = '0;
                    n_rd_live = 1'b0;
                    unique case (t_op'(i_req.operation))
                        OP_LOOKUP: n_state = ST_SCAN;
                        OP_INSERT: n_state = ST_FILL;
                        OP_REMOVE: begin
                            if (w_rm_live) begin
                                n_rm_idx = i_req.slot_in[IW-1:0];
                                n_state  = ST_READ;
                            end else begin
                                n_res   = RSP_NONE;
                                n_state = ST_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            n_valid = '0;
                            n_res   = RSP_NONE;
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_rm_idx;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                n_tgt_x           = w_rd_data.pos_x;
                n_tgt_y           = w_rd_data.pos_y;
                n_valid[r_rm_idx] = 1'b0;
                n_idx             = '0;
                n_rd_live         = 1'b0;
                n_state           = ST_SCAN;
            end
            ST_SCAN: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx;
                n_rd_idx  = r_idx;
                n_rd_live = 1'b1;
                if (r_idx != LP_LAST) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_live && (w_hit || (r_rd_idx == LP_LAST))) begin
                    n_rd_live = 1'b0;
                    n_state   = ST_DONE;
                    if (r_op == OP_REMOVE) begin
                        n_res.success     = 1'b1;
                        n_res.slot_out    = f_slot4(r_rm_idx);
                        n_res.mark_action = w_hit ? MARK_NONE : MARK_CLEAR;
                        n_res.mark_x      = w_hit ? 8'd0 : r_tgt_x;
                        n_res.mark_y      = w_hit ? 8'd0 : r_tgt_y;
                    end else begin
                        n_res          = RSP_NONE;
                        n_res.success  = w_hit;
                        n_res.slot_out = w_hit ? f_slot4(r_rd_idx) : 4'd0;
                    end
                end
            end
            ST_FILL: begin
                priority if (!r_valid[r_idx]) begin
                    w_wr_en          = 1'b1;
                    w_wr_addr        = r_idx;
                    n_valid[r_idx]   = 1'b1;
                    n_res.success     = 1'b1;
                    n_res.slot_out    = f_slot4(r_idx);
                    n_res.mark_action = MARK_SET;
                    n_res.mark_x      = r_tgt_x;
                    n_res.mark_y      = r_tgt_y;
                    n_state           = ST_DONE;
                end else if (r_idx == LP_LAST) begin
                    n_res   = RSP_NONE;
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_rd_live   <= n_rd_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_tgt_x  <= n_tgt_x;
        r_tgt_y  <= n_tgt_y;
        r_kind   <= n_kind;
        r_amount <= n_amount;
        r_rm_idx <= n_rm_idx;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.success     = r_out.success;
    assign o_rsp.slot_out    = r_out.slot_out;
    assign o_rsp.mark_action = r_out.mark_action;
    assign o_rsp.mark_x      = r_out.mark_x;
    assign o_rsp.mark_y      = r_out.mark_y;

    `ASSERT_CLK(a_fail_is_quiet, i_clk, i_rst_n, (o_rsp.valid && !o_rsp.success) |-> (o_rsp.slot_out == 4'd0 && o_rsp.mark_action == MARK_NONE))
    `ASSERT_CLK(a_set_needs_success, i_clk, i_rst_n, (o_rsp.valid && o_rsp.mark_action == MARK_SET) |-> o_rsp.success)
    `ASSERT_CLK(a_clear_empties, i_clk, i_rst_n, (w_accept && i_req.operation == OP_CLEAR) |=> (r_valid == '0))
    `ASSERT_CLK(a_removed_slot_freed, i_clk, i_rst_n, (r_state == ST_LOAD) |=> !r_valid[$past(r_rm_idx)])
    `ASSERT_NEVER(a_scan_in_range, i_clk, i_rst_n, (r_state == ST_SCAN || r_state == ST_FILL) && (r_idx > LP_LAST))

endmodule
